// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the deque RTL.
// No dependencies; the files that check their logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Expression must hold at every clock edge outside reset.
`define AST_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define AST_ALWAYS(lbl, clk, rst_n, expr)
`define AST_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/cdq_pkg.sv -----
// Package for the circular deque: field widths, command and status codes,
// and the controller-to-datapath command struct. No dependencies.
package cdq_pkg;

  localparam int DEPTH_DEF   = 64;
  localparam int VALUE_W_DEF = 16;

  localparam int CMD_W   = 3;
  localparam int FIELD_W = 16;
  localparam int STAT_W  = 2;

  localparam logic [CMD_W-1:0] CMD_NONE       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // exec: apply the accepted command; load: refresh cached end values
  typedef struct packed {
    logic exec;
    logic load;
  } ctl_cmd_t;

endpackage

// ----- rtl/cdq_ctrl.sv -----
// Controller for the circular deque: sequences accept, cache refresh and
// result transfer. Depends on cdq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output cdq_pkg::ctl_cmd_t ctl
);
  import cdq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       in_xfer;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);
  assign in_xfer   = in_valid && !in_stall;
  assign ctl.exec  = in_xfer;
  assign ctl.load  = (state_r == S_LOAD);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_RESP;
      S_RESP: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `AST_ALWAYS(a_one_in_flight, clk, rst_n, !(out_valid && !in_stall))
  `AST_NEXT(a_accept_to_load, clk, rst_n, in_xfer, ctl.load)
  `AST_NEXT(a_load_to_resp, clk, rst_n, ctl.load, out_valid)
  `AST_NEXT(a_held_result, clk, rst_n, out_valid && out_stall, out_valid)

endmodule

// ----- rtl/cdq_dpath.sv -----
// Datapath for the circular deque: entry memory, head/tail/occupancy,
// cached end values and result registers. Depends on cdq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cdq_dpath #(
  parameter int DEPTH       = cdq_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = cdq_pkg::VALUE_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cdq_pkg::ctl_cmd_t           ctl,
  input  logic [cdq_pkg::CMD_W-1:0]   in_command,
  input  logic [cdq_pkg::FIELD_W-1:0] in_value_in,
  output logic [cdq_pkg::FIELD_W-1:0] out_popped_value,
  output logic [cdq_pkg::FIELD_W-1:0] out_front_value,
  output logic [cdq_pkg::FIELD_W-1:0] out_rear_value,
  output logic                        out_is_empty,
  output logic                        out_is_full,
  output logic [cdq_pkg::STAT_W-1:0]  out_status
);
  import cdq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [OW-1:0] FULL_OCC = OW'(DEPTH);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];

  logic [AW-1:0]          head_r, head_nxt, tail_r, tail_nxt;
  logic [OW-1:0]          occ_r, occ_nxt;
  logic [VALUE_WIDTH-1:0] front_r, front_nxt, rear_r, rear_nxt;
  logic [VALUE_WIDTH-1:0] popped_r, popped_nxt, rdata_r;
  logic [STAT_W-1:0]      stat_r, stat_nxt;
  logic                   ldf_r, ldf_nxt, ldr_r, ldr_nxt;

  logic [VALUE_WIDTH-1:0] val;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic                   wr_en;
  logic                   is_push, is_pop, empty, full;

  function automatic logic [AW-1:0] wrap_up(input logic [AW-1:0] i);
    return (i == LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] wrap_dn(input logic [AW-1:0] i);
    return (i == '0) ? LAST : i - 1'b1;
  endfunction

  assign val     = VALUE_WIDTH'(in_value_in);
  assign is_push = (in_command == CMD_PUSH_FRONT) || (in_command == CMD_PUSH_REAR);
  assign is_pop  = (in_command == CMD_POP_FRONT) || (in_command == CMD_POP_REAR);
  assign empty   = (occ_r == '0);
  assign full    = (occ_r == FULL_OCC);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    occ_nxt    = occ_r;
    front_nxt  = front_r;
    rear_nxt   = rear_r;
    popped_nxt = popped_r;
    stat_nxt   = stat_r;
    ldf_nxt    = ldf_r;
    ldr_nxt    = ldr_r;
    wr_en      = 1'b0;
    wr_addr    = head_r;
    rd_addr    = head_r;

    if (ctl.exec) begin
      popped_nxt = '0;
      stat_nxt   = ST_OK;
      ldf_nxt    = 1'b0;
      ldr_nxt    = 1'b0;
      if (is_push) begin
        if (full) begin
          stat_nxt = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          occ_nxt = occ_r + 1'b1;
          if (empty) begin
            // first entry restarts the ring at slot zero
            head_nxt  = '0;
            tail_nxt  = '0;
            wr_addr   = '0;
            front_nxt = val;
            rear_nxt  = val;
          end else if (in_command == CMD_PUSH_FRONT) begin
            head_nxt  = wrap_dn(head_r);
            wr_addr   = head_nxt;
            front_nxt = val;
          end else begin
            tail_nxt = wrap_up(tail_r);
            wr_addr  = tail_nxt;
            rear_nxt = val;
          end
        end
      end else if (is_pop) begin
        if (empty) begin
          stat_nxt = ST_EMPTY;
        end else begin
          occ_nxt = occ_r - 1'b1;
          if (in_command == CMD_POP_FRONT) begin
            popped_nxt = front_r;
            if (occ_r > OW'(1)) begin
              head_nxt = wrap_up(head_r);
              rd_addr  = head_nxt;
              ldf_nxt  = 1'b1;
            end
          end else begin
            popped_nxt = rear_r;
            if (occ_r > OW'(1)) begin
              tail_nxt = wrap_dn(tail_r);
              rd_addr  = tail_nxt;
              ldr_nxt  = 1'b1;
            end
          end
        end
      end
    end

    if (ctl.load) begin
      if (ldf_r) front_nxt = rdata_r;
      if (ldr_r) rear_nxt = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= val;
    if (ctl.exec) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      occ_r  <= '0;
      stat_r <= ST_OK;
      ldf_r  <= 1'b0;
      ldr_r  <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      occ_r  <= occ_nxt;
      stat_r <= stat_nxt;
      ldf_r  <= ldf_nxt;
      ldr_r  <= ldr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_r  <= front_nxt;
    rear_r   <= rear_nxt;
    popped_r <= popped_nxt;
  end

  assign out_popped_value = FIELD_W'(popped_r);
  assign out_front_value  = empty ? '0 : FIELD_W'(front_r);
  assign out_rear_value   = empty ? '0 : FIELD_W'(rear_r);
  assign out_is_empty     = empty;
  assign out_is_full      = full;
  assign out_status       = stat_r;

  `AST_ALWAYS(a_occ_bound, clk, rst_n, occ_r <= FULL_OCC)
  `AST_ALWAYS(a_single_entry, clk, rst_n, occ_r != OW'(1) || head_r == tail_r)
  `AST_NEXT(a_reject_full, clk, rst_n, ctl.exec && is_push && full,
            full && stat_r == ST_FULL)
  `AST_NEXT(a_reject_empty, clk, rst_n, ctl.exec && is_pop && empty,
            empty && stat_r == ST_EMPTY)

endmodule

// ----- rtl/circular_deque.sv -----
// Circular deque top level: controller plus datapath.
// Depends on cdq_pkg, cdq_ctrl and cdq_dpath.
//
// Usage: a double-ended queue of DEPTH entries held in a ring buffer.
// Input channel (in_valid/in_stall) carries a command and a value: none,
// push front, push rear, pop front or pop rear. Every accepted command
// yields exactly one result on the output channel (out_valid/out_stall):
// popped value, front and rear peeks, empty/full flags and a status
// (ok, push rejected while full, pop rejected while empty).
// An accepted command passes through the load state, which refreshes the
// cached end values, then the result state, in which out_valid is high.
// One command is in flight at a time: a new command is accepted only once
// the previous result has transferred. The load state serves the entry
// memory read of the new end after a pop, with its registered read data.
// When the receiver stalls, the result is held and in_stall stays high
// until the transfer completes.
// Reset (rst_n low, synchronous) empties the queue; memory contents are
// not cleared, and stale entries are never observed.
module circular_deque #(
  parameter int DEPTH       = cdq_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = cdq_pkg::VALUE_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cdq_pkg::CMD_W-1:0]   in_command,
  input  logic [cdq_pkg::FIELD_W-1:0] in_value_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cdq_pkg::FIELD_W-1:0] out_popped_value,
  output logic [cdq_pkg::FIELD_W-1:0] out_front_value,
  output logic [cdq_pkg::FIELD_W-1:0] out_rear_value,
  output logic                        out_is_empty,
  output logic                        out_is_full,
  output logic [cdq_pkg::STAT_W-1:0]  out_status
);
  import cdq_pkg::*;

  ctl_cmd_t ctl;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  cdq_dpath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .in_command       (in_command),
    .in_value_in      (in_value_in),
    .out_popped_value (out_popped_value),
    .out_front_value  (out_front_value),
    .out_rear_value   (out_rear_value),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full),
    .out_status       (out_status)
  );

endmodule

// ----- sim/circular_deque_tb.sv -----
// Testbench for circular_deque: directed and random command streams with a
// mirrored deque that predicts every result. Depends on cdq_pkg and the RTL.
`timescale 1ns / 1ps

module circular_deque_tb;
  import cdq_pkg::*;

  localparam int QDEPTH = DEPTH_DEF;
  localparam int WORK_ITEMS = 1800;
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_MID   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [FIELD_W-1:0] popped;
    logic [FIELD_W-1:0] front;
    logic [FIELD_W-1:0] rear;
    logic               empty;
    logic               full;
    logic [STAT_W-1:0]  status;
  } deque_view_t;

  // Mirror of the deque: applies each accepted command and queues the view
  // the block should report for it.
  class deque_mirror;
    logic [FIELD_W-1:0] slots[QDEPTH];
    int head;
    int tail;
    int fill;
    int faults;
    deque_view_t due[$];

    function new();
      head = 0;
      tail = 0;
      fill = 0;
      faults = 0;
    endfunction

    function void apply_command(logic [CMD_W-1:0] cmd, logic [FIELD_W-1:0] val);
      deque_view_t v;
      v = '0;
      v.status = ST_OK;
      case (cmd)
        CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
          if (fill == QDEPTH) begin
            v.status = ST_FULL;
          end else begin
            if (fill == 0) begin
              head = 0;
              tail = 0;
              slots[0] = val;
            end else if (cmd == CMD_PUSH_FRONT) begin
              head = (head == 0) ? QDEPTH - 1 : head - 1;
              slots[head] = val;
            end else begin
              tail = (tail == QDEPTH - 1) ? 0 : tail + 1;
              slots[tail] = val;
            end
            fill++;
          end
        end
        CMD_POP_FRONT, CMD_POP_REAR: begin
          if (fill == 0) begin
            v.status = ST_EMPTY;
          end else begin
            // the last entry leaves the indices where they are
            if (cmd == CMD_POP_FRONT) begin
              v.popped = slots[head];
              if (fill > 1) head = (head == QDEPTH - 1) ? 0 : head + 1;
            end else begin
              v.popped = slots[tail];
              if (fill > 1) tail = (tail == 0) ? QDEPTH - 1 : tail - 1;
            end
            fill--;
          end
        end
        default: ;
      endcase
      v.front = (fill != 0) ? slots[head] : '0;
      v.rear  = (fill != 0) ? slots[tail] : '0;
      v.empty = (fill == 0);
      v.full  = (fill == QDEPTH);
      due.push_back(v);
    endfunction

    function void match_field(string name, logic [FIELD_W-1:0] exp, logic [FIELD_W-1:0] act);
      if (act !== exp) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, act);
        faults++;
      end
    endfunction

    function void compare_view(deque_view_t act);
      deque_view_t exp;
      if (due.size() == 0) begin
        $display("%0t: result with none outstanding, got %p", $time, act);
        faults++;
      end else begin
        exp = due.pop_front();
        match_field("popped_value", exp.popped, act.popped);
        match_field("front_value", exp.front, act.front);
        match_field("rear_value", exp.rear, act.rear);
        match_field("is_empty", exp.empty, act.empty);
        match_field("is_full", exp.full, act.full);
        match_field("status", exp.status, act.status);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [CMD_W-1:0]   in_command;
  logic [FIELD_W-1:0] in_value_in;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [FIELD_W-1:0] out_popped_value;
  logic [FIELD_W-1:0] out_front_value;
  logic [FIELD_W-1:0] out_rear_value;
  logic               out_is_empty;
  logic               out_is_full;
  logic [STAT_W-1:0]  out_status;

  logic calm;
  deque_mirror mirror = new();

  circular_deque uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_value_in      (in_value_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_popped_value (out_popped_value),
    .out_front_value  (out_front_value),
    .out_rear_value   (out_rear_value),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full),
    .out_status       (out_status)
  );

  always #2 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 32);
  end

  // transfer monitor on both channels
  always @(posedge clk) begin
    deque_view_t seen;
    if (rst_n) begin
      if (in_valid && !in_stall) mirror.apply_command(in_command, in_value_in);
      if (out_valid && !out_stall) begin
        seen.popped = out_popped_value;
        seen.front  = out_front_value;
        seen.rear   = out_rear_value;
        seen.empty  = out_is_empty;
        seen.full   = out_is_full;
        seen.status = out_status;
        mirror.compare_view(seen);
      end
    end
  end

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [FIELD_W-1:0] val);
    while (!calm && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_value_in <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // let the monitor queue the last transfer before checking for results due
  task automatic wait_drained();
    @(posedge clk);
    while (mirror.due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CMD_W-1:0] pick_cmd(int push_pct);
    logic [CMD_W-1:0] c;
    int r;
    r = $urandom_range(0, 99);
    if (r < 4)
      c = (r == 0) ? CMD_NONE : CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    else if ($urandom_range(0, 99) < push_pct)
      c = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
    else
      c = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
    return c;
  endfunction

  function automatic logic [FIELD_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return FIELD_W'($urandom);
  endfunction

  initial begin
    logic [CMD_W-1:0]   d_cmd[21];
    logic [FIELD_W-1:0] d_val[21];
    logic [CMD_W-1:0]   c;
    int work;
    int seg;
    int push_pct;
    int seg_len;

    // empty-queue errors, spare codes, refill at entry 0, wrap below 0
    d_cmd = '{CMD_POP_FRONT, CMD_POP_REAR, CMD_NONE, CMD_SPARE_FIRST, CMD_SPARE_MID,
              CMD_SPARE_LAST, CMD_PUSH_REAR, CMD_POP_FRONT, CMD_PUSH_FRONT,
              CMD_PUSH_FRONT, CMD_PUSH_REAR, CMD_PUSH_REAR, CMD_POP_REAR,
              CMD_POP_FRONT, CMD_POP_FRONT, CMD_POP_REAR, CMD_POP_REAR,
              CMD_PUSH_FRONT, CMD_PUSH_REAR, CMD_POP_REAR, CMD_POP_REAR};
    d_val = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
              16'hffff, 16'h0000, 16'h0000, 16'hffff, 16'h8000, 16'h0001,
              16'h0000, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'h5555,
              16'haaaa, 16'h0000, 16'hffff};

    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_command  <= CMD_NONE;
    in_value_in <= '0;
    calm        <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (d_cmd[i]) send_cmd(d_cmd[i], d_val[i]);
    in_valid <= 1'b0;
    wait_drained();

    // segments cycle fill, balanced, drain so full and empty are both hit
    work = 0;
    seg = 0;
    while (work < WORK_ITEMS) begin
      push_pct = (seg % 3 == 0) ? 80 : (seg % 3 == 1) ? 50 : 20;
      seg_len = $urandom_range(40, 160);
      repeat (seg_len) begin
        c = pick_cmd(push_pct);
        send_cmd(c, pick_value());
        if (c inside {CMD_PUSH_FRONT, CMD_PUSH_REAR, CMD_POP_FRONT, CMD_POP_REAR}) work++;
        calm <= (work >= 700 && work < 1000);
      end
      if (seg % 4 == 3) begin
        in_valid <= 1'b0;
        wait_drained();
      end
      seg++;
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (mirror.faults == 0 && mirror.due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
